FILE: hw/rtl/utlf_pkg.sv
// ----------------------------------------------------------------------------
// utlf_pkg - shared types and constants for the tank level filter
// Arithmetic constants, register map, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package utlf_pkg;

   // default echo duration width
   localparam int DURATION_BITS_DEF = 15;

   // distance scale: us * 1124 >> 8 gives Q8 centimeters
   localparam int          SCALE_BITS = 11;
   localparam logic [10:0] SCALE_Q8   = 11'd1124;
   localparam int          Q8_SHIFT   = 8;

   localparam int          DIST_BITS   = 17;
   localparam logic [16:0] DIST_MIN_Q8 = 17'd256;
   localparam logic [16:0] DIST_MAX_Q8 = 17'd128000;

   // level datapath: height is Q8 cm, 18 bits; multiplied by 1000
   localparam int          DEPTH_BITS   = 10;
   localparam int          MIN_BITS     = 7;
   localparam int          FAIL_BITS    = 3;
   localparam int          LEVEL_BITS   = 10;
   localparam int          H_BITS       = 18;
   localparam int          LEVEL_K_BITS = 10;
   localparam logic [9:0]  LEVEL_FULL   = 10'd1000;
   localparam int          QUO_BITS     = H_BITS + LEVEL_K_BITS - Q8_SHIFT;

   localparam logic [2:0]  MISS_MAX = 3'd7;

   // register reset values
   localparam logic [9:0]  DEPTH_RST = 10'd100;
   localparam logic [6:0]  MIN_RST   = 7'd20;
   localparam logic [2:0]  FAIL_RST  = 3'd5;

   localparam int CSR_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      CSR_TANK_DEPTH = 2'd0,
      CSR_MIN_DIST   = 2'd1,
      CSR_FAIL_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DIST,
      ST_CHECK,
      ST_MEDIAN,
      ST_MUL_H,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SAT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take;
      logic mul_step;
      logic mul_level;
      logic check;
      logic median;
      logic div_load;
      logic div_step;
      logic sat;
      logic emit;
   } ctrl_type;

endpackage

FILE: hw/rtl/ultrasonic_tank_level_filter_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_tank_level_filter_top - echo capture to filtered tank fill level
// Bit-serial distance scaling, three-entry median, serial level divide.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one echo capture per item (valid/ready). rsp_* returns one
//   result item per capture: valid flag, fill level in tenths of a percent,
//   filtered Q8 distance and a fresh flag. csr_* is an APB-style port with
//   tank depth at 0x0, blind distance at 0x4 and fail limit at 0x8; write it
//   only while the block is idle.
//   Timing: one item at a time. The distance scale and the level product
//   each run through a shared shift-add multiplier one bit per cycle, and
//   the level quotient through a restoring divider one bit per cycle. A
//   miss, or a reading at or below the tank bottom, skips the level product
//   and the divide.
//   A finished item sits in the output register; the next item is taken
//   while it waits, and the sequencer only stalls at its end if rsp_ready
//   stays low. Reset restores register defaults, clears the miss count,
//   the held outputs and the fill state of the median ring.
// ----------------------------------------------------------------------------
module ultrasonic_tank_level_filter_top #(
   parameter int DURATION_BITS = utlf_pkg::DURATION_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_echo_present,
   input  logic                                    req_first_level,
   input  logic [DURATION_BITS-1:0]                req_first_duration,
   input  logic                                    req_second_level,
   input  logic [DURATION_BITS-1:0]                req_second_duration,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_level_valid,
   output logic [utlf_pkg::LEVEL_BITS-1:0]         rsp_level_tenths_percent,
   output logic [utlf_pkg::DIST_BITS-1:0]          rsp_distance_q8_cm,
   output logic                                    rsp_fresh,

   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [utlf_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [31:0]                             csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);
   import utlf_pkg::*;

   localparam int PROD_A    = DURATION_BITS + SCALE_BITS;
   localparam int PROD_B    = H_BITS + LEVEL_K_BITS;
   localparam int PW        = (PROD_A > PROD_B) ? PROD_A : PROD_B;
   localparam int MW        = (DURATION_BITS > H_BITS) ? DURATION_BITS : H_BITS;
   localparam int DW        = DURATION_BITS + SCALE_BITS - Q8_SHIFT;
   localparam int STEP_MAX  = (MW > QUO_BITS) ? MW : QUO_BITS;
   localparam int CNT_W     = $clog2(STEP_MAX);

   // ---------------- configuration registers ----------------
   logic [DEPTH_BITS-1:0] depth_ff;
   logic [MIN_BITS-1:0]   min_ff;
   logic [FAIL_BITS-1:0]  fail_ff;
   logic                  csr_wr;
   csr_index_type         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RST;
         min_ff   <= MIN_RST;
         fail_ff  <= FAIL_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_TANK_DEPTH: depth_ff <= csr_pwdata[DEPTH_BITS-1:0];
            CSR_MIN_DIST:   min_ff   <= csr_pwdata[MIN_BITS-1:0];
            CSR_FAIL_LIMIT: fail_ff  <= csr_pwdata[FAIL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_TANK_DEPTH: csr_prdata = 32'(depth_ff);
         CSR_MIN_DIST:   csr_prdata = 32'(min_ff);
         CSR_FAIL_LIMIT: csr_prdata = 32'(fail_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   ctrl_type           ctrl;
   logic               reading_ok;
   logic               h_pos;
   logic               out_free;
   logic               rsp_valid_ff;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_MUL_DIST;
         ST_MUL_DIST: if (cnt_ff == CNT_W'(MW - 1)) state_in = ST_CHECK;
         ST_CHECK:    state_in = reading_ok ? ST_MEDIAN : ST_DONE;
         ST_MEDIAN:   state_in = h_pos ? ST_MUL_H : ST_DONE;
         ST_MUL_H:    if (cnt_ff == CNT_W'(MW - 1)) state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV:      if (cnt_ff == CNT_W'(QUO_BITS - 1)) state_in = ST_SAT;
         ST_SAT:      state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      req_ready      = (state_ff == ST_IDLE);
      ctrl.take      = req_ready & req_valid;
      ctrl.mul_step  = (state_ff == ST_MUL_DIST) || (state_ff == ST_MUL_H);
      ctrl.mul_level = (state_ff == ST_MUL_H);
      ctrl.check     = (state_ff == ST_CHECK);
      ctrl.median    = (state_ff == ST_MEDIAN);
      ctrl.div_load  = (state_ff == ST_DIV_LOAD);
      ctrl.div_step  = (state_ff == ST_DIV);
      ctrl.sat       = (state_ff == ST_SAT);
      ctrl.emit      = (state_ff == ST_DONE) && out_free;
   end

   // step counter restarts on every state change
   assign cnt_in = (state_in != state_ff) ? '0 : cnt_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------- shared shift-add multiplier ----------------
   logic [MW-1:0]            mcand_ff;
   logic [PW-1:0]            prod_ff;
   logic [SCALE_BITS-1:0]    mul_k;
   logic [DURATION_BITS-1:0] echo_us;
   logic [H_BITS:0]          h_wide;

   always_comb begin
      echo_us = '0;
      if (req_echo_present) begin
         if (req_first_level && (req_first_duration != '0))
            echo_us = req_first_duration;
         else if (req_second_level && (req_second_duration != '0))
            echo_us = req_second_duration;
      end
   end

   assign mul_k = ctrl.mul_level ? SCALE_BITS'(LEVEL_FULL) : SCALE_Q8;

   // MSB first: product doubles, then adds the constant on a set bit
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         mcand_ff <= MW'(echo_us);
         prod_ff  <= '0;
      end else if (ctrl.median) begin
         mcand_ff <= MW'(h_wide[H_BITS-1:0]);
         prod_ff  <= '0;
      end else if (ctrl.mul_step) begin
         mcand_ff <= {mcand_ff[MW-2:0], 1'b0};
         prod_ff  <= {prod_ff[PW-2:0], 1'b0} + (mcand_ff[MW-1] ? PW'(mul_k) : '0);
      end
   end

   // ---------------- range check, ring, median ----------------
   logic [DW-1:0]         dist_raw;
   logic [DIST_BITS-1:0]  dist_ff;
   logic [DIST_BITS-1:0]  ring_ff [3];
   logic [1:0]            ring_idx_ff;
   logic [1:0]            ring_idx_in;
   logic                  filling_ff;
   logic [FAIL_BITS-1:0]  miss_ff;
   logic [FAIL_BITS-1:0]  miss_inc;
   logic                  held_valid_ff;
   logic [LEVEL_BITS-1:0] held_level_ff;
   logic [DIST_BITS-1:0]  held_dist_ff;
   logic                  fresh_ff;
   logic [DIST_BITS-1:0]  filtered;

   function automatic logic [DIST_BITS-1:0] mid3(input logic [DIST_BITS-1:0] a,
                                                 input logic [DIST_BITS-1:0] b,
                                                 input logic [DIST_BITS-1:0] c);
      logic ab, bc, ac;
      ab = (a > b);
      bc = (b > c);
      ac = (a > c);
      if (ab == bc)      mid3 = b;
      else if (ab == ac) mid3 = c;
      else               mid3 = a;
   endfunction

   assign dist_raw   = prod_ff[DW+Q8_SHIFT-1:Q8_SHIFT];
   assign reading_ok = (32'(dist_raw) >= 32'(DIST_MIN_Q8)) &&
                       (32'(dist_raw) <= 32'(DIST_MAX_Q8));
   assign miss_inc   = (miss_ff < MISS_MAX) ? miss_ff + 3'd1 : miss_ff;
   assign ring_idx_in = (ring_idx_ff >= 2'd2) ? 2'd0 : ring_idx_ff + 2'd1;
   assign filtered   = filling_ff ? dist_ff : mid3(ring_ff[0], ring_ff[1], ring_ff[2]);

   always_ff @(posedge clock) begin
      if (ctrl.check && reading_ok) begin
         ring_ff[(ring_idx_ff > 2'd2) ? 2'd0 : ring_idx_ff] <= DIST_BITS'(dist_raw);
         dist_ff <= DIST_BITS'(dist_raw);
      end
   end

   // ---------------- level: height, full scale, serial divide ----------------
   logic [DEPTH_BITS:0]      full_wide;
   logic [DEPTH_BITS-1:0]    full_scale;
   logic [QUO_BITS-1:0]      quo_ff;
   logic [DEPTH_BITS-1:0]    rem_ff;
   logic [DEPTH_BITS:0]      rem_sh;
   logic                     rem_ge;

   assign h_wide = {1'b0, depth_ff, 8'h00} - {2'b00, filtered};
   assign h_pos  = ~h_wide[H_BITS] && (h_wide != '0);

   assign full_wide  = {1'b0, depth_ff} - {4'b0000, min_ff};
   assign full_scale = (full_wide[DEPTH_BITS] || (full_wide == '0)) ?
                       DEPTH_BITS'(1) : full_wide[DEPTH_BITS-1:0];

   // h*1000/(F*256) = floor(floor(h*1000/256)/F)
   assign rem_sh = {rem_ff, quo_ff[QUO_BITS-1]};
   assign rem_ge = (rem_sh >= {1'b0, full_scale});

   always_ff @(posedge clock) begin
      if (ctrl.div_load) begin
         quo_ff <= prod_ff[PROD_B-1:Q8_SHIFT];
         rem_ff <= '0;
      end else if (ctrl.div_step) begin
         quo_ff <= {quo_ff[QUO_BITS-2:0], rem_ge};
         rem_ff <= rem_ge ? DEPTH_BITS'(rem_sh - {1'b0, full_scale})
                          : rem_sh[DEPTH_BITS-1:0];
      end
   end

   // ---------------- held state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_idx_ff   <= '0;
         filling_ff    <= 1'b1;
         miss_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_level_ff <= '0;
         held_dist_ff  <= '0;
         fresh_ff      <= 1'b0;
      end else begin
         if (ctrl.check) begin
            fresh_ff <= reading_ok;
            if (reading_ok) begin
               ring_idx_ff <= ring_idx_in;
               if (ring_idx_in == 2'd0) filling_ff <= 1'b0;
            end else if (miss_inc >= fail_ff) begin
               held_valid_ff <= 1'b0;
               held_level_ff <= '0;
               held_dist_ff  <= '0;
               miss_ff       <= fail_ff;
            end else begin
               miss_ff <= miss_inc;
            end
         end
         if (ctrl.median) begin
            held_dist_ff  <= filtered;
            held_valid_ff <= 1'b1;
            miss_ff       <= '0;
            if (!h_pos) held_level_ff <= '0;
         end
         if (ctrl.sat) begin
            held_level_ff <= (quo_ff > QUO_BITS'(LEVEL_FULL)) ? LEVEL_FULL
                                                               : quo_ff[LEVEL_BITS-1:0];
         end
      end
   end

   // ---------------- output register ----------------
   logic                  out_valid_ff;
   logic [LEVEL_BITS-1:0] out_level_ff;
   logic [DIST_BITS-1:0]  out_dist_ff;
   logic                  out_fresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         out_valid_ff <= held_valid_ff;
         out_level_ff <= held_level_ff;
         out_dist_ff  <= held_dist_ff;
         out_fresh_ff <= fresh_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_level_valid          = out_valid_ff;
   assign rsp_level_tenths_percent = out_level_ff;
   assign rsp_distance_q8_cm       = out_dist_ff;
   assign rsp_fresh                = out_fresh_ff;

endmodule
